### hdl/sir_pkg.sv
// Shared types and constants for the SIR grid automaton step core.
// No dependencies; imported by every module of the block.
package sir_pkg;

  // Grid geometry
  localparam int MaxDim = 256;
  localparam int IdxW   = $clog2(MaxDim);
  localparam int SizeW  = $clog2(MaxDim + 1);

  // Field widths
  localparam int CellW = 2;
  localparam int RandW = 16;
  localparam int ThrW  = 17;
  localparam int CntW  = 16;

  // Depth of the queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Cell codes
  localparam logic [CellW-1:0] StSus = 2'd0;
  localparam logic [CellW-1:0] StInf = 2'd1;
  localparam logic [CellW-1:0] StRec = 2'd2;

  // Register indexes
  localparam logic [1:0] RegGridSize = 2'd0;
  localparam logic [1:0] RegBeta     = 2'd1;
  localparam logic [1:0] RegGamma    = 2'd2;

  // Default side length after reset
  localparam logic [SizeW-1:0] GridReset = SizeW'(MaxDim);

  // One interior cell whose window is complete, ready for the update rule
  typedef struct packed {
    logic [CellW-1:0] centre;
    logic             exposed;
    logic [RandW-1:0] rand_value;
    logic             last;
  } sir_item_t;

endpackage

### hdl/sir_grid_automaton_step_core.sv
// One generation step of an SIR cellular automaton on a streamed square grid.
// Top level: configuration registers, front end, queue and back end.
// Uses sir_pkg, sir_front, sir_queue and sir_back.
//
// Cells enter in raster order, one per clock when the result side keeps up,
// each with its own 16-bit random sample. The result for interior cell
// (r, c) leaves with the transaction of cell (r+1, c+1), which completes its
// 3x3 window; border cells give no result. An accepted transaction passes
// the stage 1 registers and the queue before the result register holds it.
// The front end's two 256-entry line buffers are simple dual-port memories,
// each read at one column and written at another in the same cycle, so the
// sustained rate is one cell per cycle while the result side keeps up;
// the four-slot queue to the back end absorbs short output stalls, and full
// rises once all four slots are claimed by cells still in flight. The line
// buffers need no clearing pass after reset. Write grid_size only while the
// block is idle; it restarts the generation and the running totals.
module sir_grid_automaton_step_core
  import sir_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Cell input
  input  logic             push,
  output logic             full,
  input  logic [CellW-1:0] cell_state_i,
  input  logic [RandW-1:0] rand_value_i,
  // Result output
  output logic             empty,
  input  logic             pop,
  output logic [CellW-1:0] new_state_o,
  output logic             last_cell_o,
  output logic [CntW-1:0]  susceptible_count_o,
  output logic [CntW-1:0]  infected_count_o,
  output logic [CntW-1:0]  recovered_count_o,
  // Configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [SizeW-1:0] grid_q, side;
  logic [ThrW-1:0]  beta_q, gamma_q;
  logic             cfg_wr, restart;
  logic [1:0]       reg_idx;

  logic             q_push, q_pop, q_empty;
  sir_item_t        q_in, q_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && (reg_idx == RegGridSize);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q  <= GridReset;
      beta_q  <= '0;
      gamma_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegGridSize: grid_q  <= pwdata[SizeW-1:0];
        RegBeta:     beta_q  <= pwdata[ThrW-1:0];
        RegGamma:    gamma_q <= pwdata[ThrW-1:0];
        default:     ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      RegGridSize: prdata = 32'(grid_q);
      RegBeta:     prdata = 32'(beta_q);
      RegGamma:    prdata = 32'(gamma_q);
      default:     prdata = '0;
    endcase
  end

  // Effective side length, clamped to 3..MaxDim
  always_comb begin
    if (grid_q < SizeW'(3)) begin
      side = SizeW'(3);
    end else if (grid_q > SizeW'(MaxDim)) begin
      side = SizeW'(MaxDim);
    end else begin
      side = grid_q;
    end
  end

  sir_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .cell_state_i (cell_state_i),
    .rand_value_i (rand_value_i),
    .side_i       (side),
    .restart_i    (restart),
    .q_push_o     (q_push),
    .q_item_o     (q_in),
    .q_pop_i      (q_pop)
  );

  sir_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  sir_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_empty_i           (q_empty),
    .q_item_i            (q_out),
    .q_pop_o             (q_pop),
    .beta_i              (beta_q),
    .gamma_i             (gamma_q),
    .restart_i           (restart),
    .empty_o             (empty),
    .pop_i               (pop),
    .new_state_o         (new_state_o),
    .last_cell_o         (last_cell_o),
    .susceptible_count_o (susceptible_count_o),
    .infected_count_o    (infected_count_o),
    .recovered_count_o   (recovered_count_o)
  );

endmodule

### hdl/sir_front.sv
// Front end: raster position, two line buffers and the 3x3 window.
// Emits one sir_item_t per interior cell into the queue. Uses sir_pkg.
module sir_front
  import sir_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [CellW-1:0] cell_state_i,
  input  logic [RandW-1:0] rand_value_i,
  input  logic [SizeW-1:0] side_i,
  input  logic             restart_i,
  output logic             q_push_o,
  output sir_item_t        q_item_o,
  input  logic             q_pop_i
);

  logic [IdxW-1:0]  col_q, row_q, col_eff, row_eff;
  logic [SizeW-1:0] col_nx, row_nx;
  logic             accept;

  logic             s1_valid_q;
  logic [CellW-1:0] s1_cell_q;
  logic [RandW-1:0] s1_rand_q;
  logic [IdxW-1:0]  s1_col_q, s1_row_q;

  logic [CellW-1:0] buf_a [MaxDim];
  logic [CellW-1:0] buf_b [MaxDim];
  logic [CellW-1:0] rd_a_q, rd_b_q;

  logic [CellW-1:0] win_q [9];
  logic [CellW-1:0] win_d [9];

  logic [QCntW-1:0] credit_q, credit_d;
  logic             produce, drop, exposed, last;

  assign accept = push_i && !full_o;
  assign full_o = (credit_q == '0);

  // Position of the incoming cell, restarted when out of range
  always_comb begin
    if ({1'b0, col_q} >= side_i || {1'b0, row_q} >= side_i) begin
      col_eff = '0;
      row_eff = '0;
    end else begin
      col_eff = col_q;
      row_eff = row_q;
    end
    col_nx = {1'b0, col_eff} + SizeW'(1);
    row_nx = {1'b0, row_eff};
    if (col_nx >= side_i) begin
      col_nx = '0;
      row_nx = row_nx + SizeW'(1);
      if (row_nx >= side_i) begin
        row_nx = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        col_q <= col_nx[IdxW-1:0];
        row_q <= row_nx[IdxW-1:0];
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cell_q <= cell_state_i;
      s1_rand_q <= rand_value_i;
      s1_col_q  <= col_eff;
      s1_row_q  <= row_eff;
    end
  end

  // Line buffers: read on accept, write back in stage 1 at the same column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_a_q <= buf_a[col_eff];
      rd_b_q <= buf_b[col_eff];
    end
    if (s1_valid_q) begin
      buf_b[s1_col_q] <= rd_a_q;
      buf_a[s1_col_q] <= s1_cell_q;
    end
  end

  // Shifted window as seen by the stage 1 cell
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3+0] = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = rd_b_q;
    win_d[5] = rd_a_q;
    win_d[8] = s1_cell_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  // Classify: interior cells go to the queue, border cells are dropped
  always_comb begin
    exposed = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (win_d[k] == StInf) begin
        exposed = 1'b1;
      end
    end
    produce = (s1_row_q >= IdxW'(2)) && (s1_col_q >= IdxW'(2));
    last    = ({1'b0, s1_row_q} == side_i - SizeW'(1))
           && ({1'b0, s1_col_q} == side_i - SizeW'(1));
  end

  assign drop                = s1_valid_q && !produce;
  assign q_push_o            = s1_valid_q && produce;
  assign q_item_o.centre     = win_d[4];
  assign q_item_o.exposed    = exposed;
  assign q_item_o.rand_value = s1_rand_q;
  assign q_item_o.last       = last;

  // Credits: queue slots not yet claimed by items in flight
  always_comb begin
    credit_d = credit_q;
    if (accept) begin
      credit_d = credit_d - QCntW'(1);
    end
    if (drop) begin
      credit_d = credit_d + QCntW'(1);
    end
    if (q_pop_i) begin
      credit_d = credit_d + QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= QCntW'(QDepth);
    end else begin
      credit_q <= credit_d;
    end
  end

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= QCntW'(QDepth))
    else $error("front credit count above queue depth");

  a_window_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> win_q[8] == $past(s1_cell_q))
    else $error("window did not take the stage 1 cell");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> {1'b0, s1_col_q} < side_i && {1'b0, s1_row_q} < side_i)
    else $error("stage 1 position outside the grid");

endmodule

### hdl/sir_queue.sv
// Short queue of classified cells between front and back end.
// Uses sir_pkg for the item type and depth.
module sir_queue
  import sir_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sir_item_t item_i,
  input  logic      pop_i,
  output logic      empty_o,
  output sir_item_t item_o
);

  sir_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != QCntW'(QDepth)) || pop_i)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count above depth");

endmodule

### hdl/sir_back.sv
// Back end: SIR update rule, running totals and the result register.
// Uses sir_pkg; fed by sir_queue.
module sir_back
  import sir_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  sir_item_t        q_item_i,
  output logic             q_pop_o,
  input  logic [ThrW-1:0]  beta_i,
  input  logic [ThrW-1:0]  gamma_i,
  input  logic             restart_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [CellW-1:0] new_state_o,
  output logic             last_cell_o,
  output logic [CntW-1:0]  susceptible_count_o,
  output logic [CntW-1:0]  infected_count_o,
  output logic [CntW-1:0]  recovered_count_o
);

  logic             out_valid_q;
  logic [CellW-1:0] state_q;
  logic             last_q;
  logic [CntW-1:0]  cnt_s_q, cnt_i_q, cnt_r_q;
  logic [CntW-1:0]  tot_s_q, tot_i_q, tot_r_q;
  logic [CntW-1:0]  bump_s, bump_i, bump_r;
  logic [CellW-1:0] next_state;
  logic             rand_lt_beta, rand_lt_gamma;

  assign q_pop_o = !q_empty_i && (!out_valid_q || pop_i);
  assign empty_o = !out_valid_q;

  // Update rule
  always_comb begin
    rand_lt_beta  = {1'b0, q_item_i.rand_value} < beta_i;
    rand_lt_gamma = {1'b0, q_item_i.rand_value} < gamma_i;
    case (q_item_i.centre)
      StSus:   next_state = (q_item_i.exposed && rand_lt_beta) ? StInf : StSus;
      StInf:   next_state = rand_lt_gamma ? StRec : StInf;
      default: next_state = StRec;
    endcase
  end

  // Saturating totals including this cell
  always_comb begin
    bump_s = tot_s_q;
    bump_i = tot_i_q;
    bump_r = tot_r_q;
    case (next_state)
      StSus:   bump_s = (&tot_s_q) ? tot_s_q : tot_s_q + CntW'(1);
      StInf:   bump_i = (&tot_i_q) ? tot_i_q : tot_i_q + CntW'(1);
      default: bump_r = (&tot_r_q) ? tot_r_q : tot_r_q + CntW'(1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tot_s_q     <= '0;
      tot_i_q     <= '0;
      tot_r_q     <= '0;
    end else begin
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (restart_i || (q_pop_o && q_item_i.last)) begin
        tot_s_q <= '0;
        tot_i_q <= '0;
        tot_r_q <= '0;
      end else if (q_pop_o) begin
        tot_s_q <= bump_s;
        tot_i_q <= bump_i;
        tot_r_q <= bump_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      state_q <= next_state;
      last_q  <= q_item_i.last;
      cnt_s_q <= bump_s;
      cnt_i_q <= bump_i;
      cnt_r_q <= bump_r;
    end
  end

  assign new_state_o         = state_q;
  assign last_cell_o         = last_q;
  assign susceptible_count_o = cnt_s_q;
  assign infected_count_o    = cnt_i_q;
  assign recovered_count_o   = cnt_r_q;

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_item_i.last |=> tot_s_q == '0 && tot_i_q == '0 && tot_r_q == '0)
    else $error("totals not cleared after the last cell");

  a_totals_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && !q_item_i.last && !restart_i |=>
      tot_s_q == cnt_s_q && tot_i_q == cnt_i_q && tot_r_q == cnt_r_q)
    else $error("running totals differ from the emitted counts");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |-> !q_pop_o)
    else $error("result register overwritten before it was taken");

endmodule
